[hdl/assert_macros.svh]
// Assertion macros for the RTL files of the page-table walker.
// Uses the clk and rst_n names of the including module; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/tlpw_pkg.sv]
// Package for the two-level page-table walker: sizes, codes, item types and
// the page-table entry encoder. No dependencies.
`timescale 1ns / 1ps

package tlpw_pkg;

    localparam int MAX_PAGES        = 16;
    localparam int ENTRIES_PER_PAGE = 1024;
    localparam int PAGE_W           = $clog2(MAX_PAGES);
    localparam int SLOT_W           = $clog2(ENTRIES_PER_PAGE);
    localparam int ADDR_W           = PAGE_W + SLOT_W;
    localparam int DEPTH            = MAX_PAGES * ENTRIES_PER_PAGE;
    localparam int NFP_W            = $clog2(MAX_PAGES + 1);
    localparam int CFG_W            = 5;
    localparam int PPN_W            = 20;
    localparam int OFFSET_W         = 12;
    localparam int STATUS_W         = 3;

    localparam logic OP_MAP       = 1'b0;
    localparam logic OP_TRANSLATE = 1'b1;

    localparam logic [1:0] ACC_READ  = 2'd0;
    localparam logic [1:0] ACC_WRITE = 2'd1;
    localparam logic [1:0] ACC_EXEC  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OOM  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PERM = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ADDR = 3'd4;

    // Entry bit positions.
    localparam int E_VALID   = 0;
    localparam int E_PRESENT = 1;
    localparam int E_READ    = 2;
    localparam int E_WRITE   = 3;
    localparam int E_EXEC    = 4;
    localparam int E_USER    = 5;

    typedef struct packed {
        logic        opcode;
        logic        fresh_table;
        logic [3:0]  table_page;
        logic [31:0] vaddr;
        logic        user_mode;
        logic        allow_exec;
        logic        allow_write;
        logic        allow_read;
        logic [1:0]  access_kind;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [31:0]         phys_addr;
    } out_item_t;

    // Result of checking one fetched entry.
    typedef struct packed {
        logic valid;
        logic present;
        logic perm_ok;
        logic ppn_ok;
    } chk_t;

    // Valid, present and accessed set, bit 7 set, reserved bits 11:8 clear.
    function automatic logic [31:0] make_entry(input logic [PPN_W-1:0] ppn,
                                               input in_item_t item);
        make_entry = {ppn, 4'b0000, 1'b1, 1'b1, item.user_mode, item.allow_exec,
                      item.allow_write, item.allow_read, 1'b1, 1'b1};
    endfunction

endpackage

[hdl/tlpw_entry_check.sv]
// Shared entry checker: decodes one page-table entry against the access kind,
// the privilege level and the page limit. Depends on tlpw_pkg.
`timescale 1ns / 1ps

module tlpw_entry_check (
    input  logic [31:0]              entry,
    input  logic [1:0]               access_kind,
    input  logic                     user_mode,
    input  logic [tlpw_pkg::NFP_W-1:0] limit,
    output tlpw_pkg::chk_t           chk
);
    import tlpw_pkg::*;

    logic kind_bit;

    always_comb
    begin
        case (access_kind)
            ACC_READ:  kind_bit = entry[E_READ];
            ACC_WRITE: kind_bit = entry[E_WRITE];
            ACC_EXEC:  kind_bit = entry[E_EXEC];
            default:   kind_bit = 1'b0;
        endcase
    end

    assign chk.valid   = entry[E_VALID];
    assign chk.present = entry[E_PRESENT];
    assign chk.perm_ok = kind_bit && (!user_mode || entry[E_USER]);
    assign chk.ppn_ok  = entry[31:OFFSET_W] < PPN_W'(limit);

endmodule

[hdl/two_level_page_mapper_walker.sv]
// Two-level page-table walker: one 16K x 32 table store behind a single port.
// An item passes through decode, the dependent reads and writes of the store and the response
// state before its result is registered at the output; the next item is taken only after that,
// and a finished result waits while the previous one has not left the output register.
// After reset a clearing pass zeroes all 16K words of the store, one word a cycle, during which
// no item is taken; configuration writes are taken at any time.
`timescale 1ns / 1ps

module two_level_page_mapper_walker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [4:0]            cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tlpw_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tlpw_pkg::out_item_t   out_data
);
    import tlpw_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_TOP    = 3'd3;
    localparam logic [2:0] S_SEC    = 3'd4;
    localparam logic [2:0] S_WR_TOP = 3'd5;
    localparam logic [2:0] S_WR_SEC = 3'd6;
    localparam logic [2:0] S_RESP   = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [CFG_W-1:0]    piu_reg;
    logic [NFP_W-1:0]    nfp_reg, nfp_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg, out_data_next;
    in_item_t            item_reg, item_next;
    logic [PAGE_W-1:0]   top_page_reg, top_page_next;
    logic [PAGE_W-1:0]   sec_page_reg, sec_page_next;
    logic [PAGE_W-1:0]   leaf_ppn_reg, leaf_ppn_next;
    logic [1:0]          alloc_reg, alloc_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [31:0]         res_pa_reg, res_pa_next;

    logic [31:0]         mem [DEPTH];
    logic [31:0]         rd_data_reg;
    logic [ADDR_W-1:0]   mem_addr;
    logic                mem_we;
    logic [31:0]         mem_wdata;

    logic [NFP_W-1:0]    lim;
    logic [NFP_W+1:0]    nfp_ext;
    logic                fits1, fits2, fits3;
    logic                tp_bad;
    logic [SLOT_W-1:0]   top_slot, sec_slot;
    logic [PAGE_W-1:0]   rd_page;
    chk_t                chk;
    logic                out_err;

    assign lim = (piu_reg < CFG_W'(MAX_PAGES)) ? NFP_W'(piu_reg) : NFP_W'(MAX_PAGES);
    assign nfp_ext = (NFP_W+2)'(nfp_reg);
    assign fits1 = (nfp_ext + (NFP_W+2)'(1)) <= (NFP_W+2)'(lim);
    assign fits2 = (nfp_ext + (NFP_W+2)'(2)) <= (NFP_W+2)'(lim);
    assign fits3 = (nfp_ext + (NFP_W+2)'(3)) <= (NFP_W+2)'(lim);
    assign tp_bad = (item_reg.table_page == 4'd0) || (NFP_W'(item_reg.table_page) >= lim);
    assign top_slot = item_reg.vaddr[31:22];
    assign sec_slot = item_reg.vaddr[21:12];
    assign rd_page = rd_data_reg[OFFSET_W +: PAGE_W];

    // The same checker serves the top-level and the leaf entry.
    tlpw_entry_check u_check (
        .entry       (rd_data_reg),
        .access_kind (item_reg.access_kind),
        .user_mode   (item_reg.user_mode),
        .limit       (lim),
        .chk         (chk)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        nfp_next        = nfp_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        item_next       = item_reg;
        top_page_next   = top_page_reg;
        sec_page_next   = sec_page_reg;
        leaf_ppn_next   = leaf_ppn_reg;
        alloc_next      = alloc_reg;
        res_status_next = res_status_reg;
        res_pa_next     = res_pa_reg;
        mem_addr        = {PAGE_W'(item_reg.table_page), top_slot};
        mem_we          = 1'b0;
        mem_wdata       = make_entry(PPN_W'(leaf_ppn_reg), item_reg);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_addr     = clr_cnt_reg;
                mem_we       = 1'b1;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                // The top entry read is issued here in every case.
                res_pa_next = '0;
                if (item_reg.opcode == OP_MAP && item_reg.fresh_table)
                begin
                    if (!fits3)
                    begin
                        res_status_next = ST_OOM;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        top_page_next = PAGE_W'(nfp_reg);
                        sec_page_next = PAGE_W'(nfp_reg + NFP_W'(1));
                        leaf_ppn_next = PAGE_W'(nfp_reg + NFP_W'(2));
                        alloc_next    = 2'd3;
                        state_next    = S_WR_TOP;
                    end
                end
                else if (tp_bad)
                begin
                    res_status_next = ST_ADDR;
                    state_next      = S_RESP;
                end
                else
                begin
                    top_page_next = PAGE_W'(item_reg.table_page);
                    state_next    = S_TOP;
                end
            end
            S_TOP:
            begin
                mem_addr = {rd_page, sec_slot};
                if (item_reg.opcode == OP_TRANSLATE)
                begin
                    if (!chk.valid)
                    begin
                        res_status_next = ST_ADDR;
                        state_next      = S_RESP;
                    end
                    else if (!chk.perm_ok)
                    begin
                        res_status_next = ST_PERM;
                        state_next      = S_RESP;
                    end
                    else if (!chk.present || !chk.ppn_ok)
                    begin
                        res_status_next = ST_ADDR;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SEC;
                    end
                end
                else if (chk.valid)
                begin
                    if (!chk.ppn_ok)
                    begin
                        res_status_next = ST_ADDR;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        sec_page_next = rd_page;
                        state_next    = S_SEC;
                    end
                end
                else if (!fits2)
                begin
                    res_status_next = ST_OOM;
                    state_next      = S_RESP;
                end
                else
                begin
                    sec_page_next = PAGE_W'(nfp_reg);
                    leaf_ppn_next = PAGE_W'(nfp_reg + NFP_W'(1));
                    alloc_next    = 2'd2;
                    state_next    = S_WR_TOP;
                end
            end
            S_SEC:
            begin
                if (item_reg.opcode == OP_TRANSLATE)
                begin
                    if (!chk.valid || !chk.present)
                    begin
                        res_status_next = ST_ADDR;
                    end
                    else if (!chk.perm_ok)
                    begin
                        res_status_next = ST_PERM;
                    end
                    else
                    begin
                        res_status_next = ST_OK;
                        res_pa_next     = {rd_data_reg[31:OFFSET_W],
                                           item_reg.vaddr[OFFSET_W-1:0]};
                    end
                    state_next = S_RESP;
                end
                else if (chk.valid)
                begin
                    res_status_next = ST_DUP;
                    state_next      = S_RESP;
                end
                else if (!fits1)
                begin
                    res_status_next = ST_OOM;
                    state_next      = S_RESP;
                end
                else
                begin
                    leaf_ppn_next = PAGE_W'(nfp_reg);
                    alloc_next    = 2'd1;
                    state_next    = S_WR_SEC;
                end
            end
            S_WR_TOP:
            begin
                mem_addr   = {top_page_reg, top_slot};
                mem_we     = 1'b1;
                mem_wdata  = make_entry(PPN_W'(sec_page_reg), item_reg);
                state_next = S_WR_SEC;
            end
            S_WR_SEC:
            begin
                mem_addr        = {sec_page_reg, sec_slot};
                mem_we          = 1'b1;
                nfp_next        = nfp_reg + NFP_W'(alloc_reg);
                res_status_next = ST_OK;
                // For a new process the top table page is the one just taken.
                res_pa_next     = 32'({top_page_reg, {OFFSET_W{1'b0}}});
                state_next      = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.status    = res_status_reg;
                    out_data_next.phys_addr = res_pa_reg;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            piu_reg       <= CFG_W'(16);
            nfp_reg       <= NFP_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            nfp_reg       <= nfp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                piu_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        item_reg       <= item_next;
        top_page_reg   <= top_page_next;
        sec_page_reg   <= sec_page_next;
        leaf_ppn_reg   <= leaf_ppn_next;
        alloc_reg      <= alloc_next;
        res_status_reg <= res_status_next;
        res_pa_reg     <= res_pa_next;
    end

    // Table store: one port, registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    assign out_err = out_valid && (out_data.status != ST_OK);

`include "assert_macros.svh"

    `ASSERT_CLK(a_nfp_bound, nfp_reg <= NFP_W'(MAX_PAGES), "page counter beyond the store")
    `ASSERT_CLK(a_nfp_alloc, $changed(nfp_reg) |-> $past(state_reg) == S_WR_SEC, "early page take")
    `ASSERT_CLK(a_err_pa_zero, out_err |-> out_data.phys_addr == '0, "address on an error result")

endmodule
